// ===== rtl/trce_pkg.sv =====
// Package for the transport receiver connection engine.
// Holds codes for actions, segment types, slot modes and status. No dependencies.
package trce_pkg;
  localparam logic [2:0] ACT_SEGMENT = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_LISTEN  = 3'd2;
  localparam logic [2:0] ACT_CONSUME = 3'd3;
  localparam logic [2:0] ACT_CLOSE   = 3'd4;
  localparam logic [2:0] ACT_TICK    = 3'd5;

  localparam logic [2:0] SEG_SYN     = 3'd0;
  localparam logic [2:0] SEG_SYNACK  = 3'd1;
  localparam logic [2:0] SEG_FIN     = 3'd2;
  localparam logic [2:0] SEG_FINACK  = 3'd3;
  localparam logic [2:0] SEG_DATA    = 3'd4;
  localparam logic [2:0] SEG_DATAACK = 3'd5;

  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_LISTEN = 2'd1;
  localparam logic [1:0] MODE_CONN   = 2'd2;
  localparam logic [1:0] MODE_CWAIT  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SLOT  = 3'd1;
  localparam logic [2:0] ST_NO_PORT  = 3'd2;
  localparam logic [2:0] ST_BAD_STATE = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  seg_type;
    logic [15:0] seg_dest_port;
    logic [15:0] seg_src_port;
    logic [31:0] seg_seq;
    logic [10:0] seg_len;
    logic [15:0] new_port;
    logic [2:0]  slot_sel;
    logic [16:0] consume_len;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [1:0]  slot_state;
    logic        reply_valid;
    logic [2:0]  reply_type;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dest_port;
    logic [31:0] reply_ack;
    logic        data_stored;
    logic [16:0] store_offset;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage

// ===== rtl/trce_if.sv =====
// Valid/ready channel interfaces for request, response and configuration.
// Depends on trce_pkg.
interface trce_req_if import trce_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trce_rsp_if import trce_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface trce_cfg_if ();
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/trce_ctrl.sv =====
// Controller state machine of the connection engine.
// Depends on trce_pkg; drives the datapath by cmd_t and reads sts_t.
module trce_ctrl import trce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.scan = (state == S_SCAN);
    cmd.exec = (state == S_EXEC);
  end
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_SCAN;
        S_SCAN: if (sts.scan_done) state <= S_EXEC;
        S_EXEC: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_SCAN)
    else $error("accepted request did not start scan");
  assert property (@(posedge clk) disable iff (rst) cmd.exec |=> out_valid)
    else $error("execute did not raise result");
endmodule

// ===== rtl/trce_dp.sv =====
// Datapath of the connection engine: slot table, port scan, slot update.
// Depends on trce_pkg; commanded by trce_ctrl.
module trce_dp import trce_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int BUFFER_BYTES = 65536,
  parameter int SEGMENT_PAYLOAD_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  req_t        req_in,
  input  logic [15:0] cw_ticks,
  output sts_t        sts,
  output rsp_t        rsp
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int BW = $clog2(BUFFER_BYTES + 1);

  logic [SLOTS-1:0] vld;
  logic [1:0]  mode [SLOTS];
  logic [15:0] sport [SLOTS];
  logic [15:0] cport [SLOTS];
  logic [31:0] eseq [SLOTS];
  logic [BW-1:0] used [SLOTS];
  logic [15:0] cwc [SLOTS];

  req_t req;
  logic [CW-1:0] scan_idx;
  logic found;
  logic [IW-1:0] hit;

  assign sts.scan_done = (scan_idx == CW'(SLOTS));

  // Free slot and selection checks use valid bits only, which are flip-flops.
  logic free_found;
  logic [IW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic sel_in;
  logic [IW-1:0] sel;
  logic sel_ok;
  assign sel_in = ({4'b0000, req.slot_sel} < 7'(SLOTS));
  assign sel = sel_in ? IW'(req.slot_sel) : '0;
  assign sel_ok = sel_in && vld[sel];

  // Scan checks one slot per cycle for the lowest port match.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
      scan_idx <= '0;
      found <= 1'b0;
      hit <= '0;
    end else if (cmd.scan && !sts.scan_done) begin
      scan_idx <= scan_idx + 1'b1;
      if (!found && vld[scan_idx[IW-1:0]] &&
          sport[scan_idx[IW-1:0]] == req.seg_dest_port) begin
        found <= 1'b1;
        hit <= scan_idx[IW-1:0];
      end
    end
  end

  logic [1:0] hm;
  logic [BW:0] fit;
  logic data_ok;
  logic [31:0] new_seq;
  assign hm = mode[hit];
  assign fit = {1'b0, used[hit]} + (BW+1)'(req.seg_len);
  assign data_ok = (req.seg_seq == eseq[hit]) &&
                   ({5'd0, req.seg_len} <= 16'(SEGMENT_PAYLOAD_MAX)) &&
                   (fit <= (BW+1)'(BUFFER_BYTES));
  assign new_seq = eseq[hit] + {21'd0, req.seg_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      for (int i = 0; i < SLOTS; i++) mode[i] <= MODE_CLOSED;
    end else if (cmd.exec) begin
      rsp <= '0;
      case (req.action)
        ACT_SEGMENT: begin
          if (!found) rsp.status <= ST_NO_PORT;
          else begin
            rsp.slot_out <= 3'(hit);
            rsp.slot_state <= hm;
            rsp.status <= ST_IGNORED;
            // Reply ports are shown only when a reply segment goes out.
            case (hm)
              MODE_LISTEN: if (req.seg_type == SEG_SYN) begin
                mode[hit] <= MODE_CONN;
                cport[hit] <= req.seg_src_port;
                rsp.reply_src_port <= sport[hit];
                rsp.reply_dest_port <= req.seg_src_port;
                rsp.slot_state <= MODE_CONN;
                rsp.reply_valid <= 1'b1;
                rsp.reply_type <= SEG_SYNACK;
                rsp.status <= ST_OK;
              end
              MODE_CONN: begin
                if (req.seg_type == SEG_SYN) begin
                  rsp.reply_src_port <= sport[hit];
                  rsp.reply_dest_port <= cport[hit];
                  rsp.reply_valid <= 1'b1;
                  rsp.reply_type <= SEG_SYNACK;
                  rsp.status <= ST_OK;
                end else if (req.seg_type == SEG_FIN) begin
                  mode[hit] <= MODE_CWAIT;
                  cwc[hit] <= (cw_ticks == 16'd0) ? 16'd1 : cw_ticks;
                  rsp.reply_src_port <= sport[hit];
                  rsp.reply_dest_port <= cport[hit];
                  rsp.slot_state <= MODE_CWAIT;
                  rsp.reply_valid <= 1'b1;
                  rsp.reply_type <= SEG_FINACK;
                  rsp.status <= ST_OK;
                end else if (req.seg_type == SEG_DATA) begin
                  rsp.reply_src_port <= sport[hit];
                  rsp.reply_dest_port <= cport[hit];
                  rsp.reply_valid <= 1'b1;
                  rsp.reply_type <= SEG_DATAACK;
                  rsp.status <= ST_OK;
                  rsp.reply_ack <= eseq[hit];
                  if (data_ok) begin
                    rsp.data_stored <= 1'b1;
                    rsp.store_offset <= 17'(used[hit]);
                    rsp.reply_ack <= new_seq;
                    eseq[hit] <= new_seq;
                    used[hit] <= fit[BW-1:0];
                  end
                end
              end
              MODE_CWAIT: if (req.seg_type == SEG_FIN) begin
                rsp.reply_src_port <= sport[hit];
                rsp.reply_dest_port <= cport[hit];
                rsp.reply_valid <= 1'b1;
                rsp.reply_type <= SEG_FINACK;
                rsp.status <= ST_OK;
              end
              default: rsp.status <= ST_IGNORED;
            endcase
          end
        end
        ACT_CREATE: begin
          if (free_found) begin
            vld[free_idx] <= 1'b1;
            mode[free_idx] <= MODE_CLOSED;
            sport[free_idx] <= req.new_port;
            eseq[free_idx] <= '0;
            used[free_idx] <= '0;
            cwc[free_idx] <= '0;
            rsp.slot_out <= 3'(free_idx);
          end else rsp.status <= ST_NO_SLOT;
        end
        ACT_LISTEN: begin
          rsp.slot_out <= req.slot_sel;
          if (sel_ok && (mode[sel] == MODE_CLOSED || mode[sel] == MODE_LISTEN)) begin
            mode[sel] <= MODE_LISTEN;
            rsp.slot_state <= MODE_LISTEN;
          end else begin
            rsp.status <= ST_BAD_STATE;
            if (sel_ok) rsp.slot_state <= mode[sel];
          end
        end
        ACT_CONSUME: begin
          rsp.slot_out <= req.slot_sel;
          if (sel_ok) rsp.slot_state <= mode[sel];
          if (sel_ok && mode[sel] == MODE_CONN) begin
            if (32'(req.consume_len) > 32'(used[sel])) rsp.status <= ST_NO_DATA;
            else begin
              used[sel] <= used[sel] - BW'(req.consume_len);
              rsp.store_offset <= 17'(used[sel]) - req.consume_len;
            end
          end else rsp.status <= ST_BAD_STATE;
        end
        ACT_CLOSE: begin
          rsp.slot_out <= req.slot_sel;
          if (sel_ok && mode[sel] == MODE_CLOSED) vld[sel] <= 1'b0;
          else begin
            rsp.status <= ST_BAD_STATE;
            if (sel_ok) rsp.slot_state <= mode[sel];
          end
        end
        ACT_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (vld[i] && mode[i] == MODE_CWAIT) begin
              if (cwc[i] <= 16'd1) begin
                cwc[i] <= '0;
                mode[i] <= MODE_CLOSED;
              end else cwc[i] <= cwc[i] - 16'd1;
            end
          end
        end
        default: rsp.status <= ST_IGNORED;
      endcase
    end
  end
endmodule

// ===== rtl/transport_receiver_connection_engine.sv =====
// Top level of the transport receiver connection engine.
// Depends on trce_pkg, trce_if, trce_ctrl and trce_dp.
//
//  channel | direction | payload
//  req     | in        | action and segment / socket request fields
//  rsp     | out       | status, slot, reply segment and buffer offset
//  cfg     | in        | closewait_ticks, 16 bits
//
// Each request passes through the serial port scan over the slot table,
// then an execute state and an output state before its result is shown.
// Reset is synchronous on rst and frees every slot at once.
// A result that is not taken holds the block; the next request waits.
// Configuration writes are always taken.
module transport_receiver_connection_engine import trce_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int BUFFER_BYTES = 65536,
  parameter int SEGMENT_PAYLOAD_MAX = 1024
) (
  input logic clk,
  input logic rst,
  trce_req_if.sink   req,
  trce_rsp_if.source rsp,
  trce_cfg_if.sink   cfg
);
  cmd_t cmd;
  sts_t sts;
  logic [15:0] cw_ticks;

  // The register is always ready to take a configuration write.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) cw_ticks <= 16'd1000;
    else if (cfg.valid) cw_ticks <= cfg.data;
  end

  trce_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .cmd(cmd)
  );

  trce_dp #(
    .SLOTS(SLOTS), .BUFFER_BYTES(BUFFER_BYTES),
    .SEGMENT_PAYLOAD_MAX(SEGMENT_PAYLOAD_MAX)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req_in(req.data),
    .cw_ticks(cw_ticks), .sts(sts), .rsp(rsp.data)
  );
endmodule
